>>> hw/rtl/slpa_pkg.sv
// shared constants for the least penetration axis block: parameter defaults,
// command and status codes. no dependencies
`timescale 1ns / 1ps
package slpa_pkg;

  localparam int MAX_VERTICES_DEF = 8;
  localparam int FRAC_BITS_DEF    = 16;

  localparam int CMD_W = 3;
  localparam logic [CMD_W-1:0] CMD_LOAD_A = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POSE_A = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POSE_B = 3'd3;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd4;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

endpackage

>>> hw/rtl/sat_least_penetration_axis.sv
// sat axis of least penetration between two convex polygons, q16.16 fixed point
// loads, poses and queries arrive as commands; a query returns one result transfer.
// a query is computed on the single shared multiplier doing one product per cycle;
// the result strobe is registered after the last face. an empty polygon answers in
// the cycle after start.
// reset clears counts and positions and sets both rotations to identity.
`timescale 1ns / 1ps
module sat_least_penetration_axis #(
  parameter int MAX_VERTICES = slpa_pkg::MAX_VERTICES_DEF,
  parameter int FRAC_BITS    = slpa_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic [slpa_pkg::CMD_W-1:0]       in_cmd,
  input  logic [$clog2(MAX_VERTICES)-1:0]  in_index,
  input  logic                             in_last_vertex,
  input  logic signed [31:0]               in_px,
  input  logic signed [31:0]               in_py,
  input  logic signed [17:0]               in_nx,
  input  logic signed [17:0]               in_ny,
  input  logic signed [17:0]               in_m00,
  input  logic signed [17:0]               in_m01,
  input  logic signed [17:0]               in_m10,
  input  logic signed [17:0]               in_m11,
  output logic                             out_valid,
  output logic signed [31:0]               out_distance,
  output logic [$clog2(MAX_VERTICES)-1:0]  out_face_index,
  output logic                             out_status
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);

  // magnitude exponents of each intermediate, widths capped at the 64-bit wrap
  localparam int ROT_W  = (FRAC_BITS + 2 > 18) ? FRAC_BITS + 2 : 18;
  localparam int R_E    = (FRAC_BITS > 17) ? FRAC_BITS : 17;
  localparam int N1_E   = R_E + 18 - FRAC_BITS;
  localparam int N2_E   = R_E + N1_E + 1 - FRAC_BITS;
  localparam int V1_E   = R_E + 32 - FRAC_BITS;
  localparam int V1P_E  = ((V1_E > 32) ? V1_E : 32) + 1;
  localparam int V2_E   = R_E + V1P_E + 1 - FRAC_BITS;
  localparam int D_E    = ((V2_E > 31) ? V2_E : 31) + 1;
  localparam int N1_W   = (N1_E + 2 > 64) ? 64 : N1_E + 2;
  localparam int N2_W   = (N2_E + 2 > 64) ? 64 : N2_E + 2;
  localparam int V1P_W  = (V1P_E + 2 > 64) ? 64 : V1P_E + 2;
  localparam int V2_W   = (V2_E + 2 > 64) ? 64 : V2_E + 2;
  localparam int D_W    = (D_E + 2 > 64) ? 64 : D_E + 2;
  localparam int AW     = (N2_W > ROT_W) ? N2_W : ROT_W;
  localparam int BW_0   = (N1_W > 32) ? N1_W : 32;
  localparam int BW_1   = (V1P_W > BW_0) ? V1P_W : BW_0;
  localparam int BW     = (D_W > BW_1) ? D_W : BW_1;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AFETCH = 4'd1;
  localparam logic [3:0] S_N1X    = 4'd2;
  localparam logic [3:0] S_N1Y    = 4'd3;
  localparam logic [3:0] S_N2X    = 4'd4;
  localparam logic [3:0] S_N2Y    = 4'd5;
  localparam logic [3:0] S_V1X    = 4'd6;
  localparam logic [3:0] S_V1Y    = 4'd7;
  localparam logic [3:0] S_V2X    = 4'd8;
  localparam logic [3:0] S_V2Y    = 4'd9;
  localparam logic [3:0] S_BFETCH = 4'd10;
  localparam logic [3:0] S_SUP    = 4'd11;
  localparam logic [3:0] S_DIST   = 4'd12;

  localparam logic [1:0] PH_LAST = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [1:0] ph_r;

  logic signed [ROT_W-1:0] rot_a_r [4];
  logic signed [ROT_W-1:0] rot_b_r [4];
  logic signed [31:0] pos_ax_r, pos_ay_r, pos_bx_r, pos_by_r;
  logic [CNT_W-1:0] cnt_a_r, cnt_b_r, face_r, k_r;

  logic signed [N1_W-1:0]  n1x_r, n1y_r;
  logic signed [N2_W-1:0]  n2x_r, n2y_r;
  logic signed [V1P_W-1:0] wx_r, wy_r;
  logic signed [V2_W-1:0]  v2x_r, v2y_r;
  logic signed [31:0]      bx_r, by_r;
  logic signed [63:0]      bestp_r, bestd_r, acc_r, prod_r;
  logic [IDX_W-1:0]        besti_r;

  logic                    out_valid_r;
  logic signed [31:0]      out_distance_r;
  logic [IDX_W-1:0]        out_face_index_r;
  logic                    out_status_r;

  logic accept, idx_ok;
  logic we_a, we_b, re_a, re_b;
  logic [63:0] va_dout, vb_dout;
  logic [35:0] na_dout;

  logic signed [AW-1:0]      op_a;
  logic signed [BW-1:0]      op_b;
  logic signed [AW+BW-1:0]   mul_c;
  logic signed [63:0]        sum_c, sh_c, p_c, dx_c, dy_c;
  logic                      dot_state, sel;

  assign accept = start && !busy;
  assign idx_ok = (CNT_W + 1)'(in_index) < (CNT_W + 1)'(MAX_VERTICES);
  assign we_a   = accept && (in_cmd == slpa_pkg::CMD_LOAD_A) && idx_ok;
  assign we_b   = accept && (in_cmd == slpa_pkg::CMD_LOAD_B) && idx_ok;
  assign re_a   = (state_r == S_AFETCH);
  assign re_b   = (state_r == S_BFETCH);

  slpa_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_verts_a (
    .clk(clk), .we(we_a), .waddr(in_index), .wdata({in_px, in_py}),
    .re(re_a), .raddr(face_r[IDX_W-1:0]), .rdata(va_dout)
  );

  slpa_ram #(.WIDTH(36), .DEPTH(MAX_VERTICES)) u_normals_a (
    .clk(clk), .we(we_a), .waddr(in_index), .wdata({in_nx, in_ny}),
    .re(re_a), .raddr(face_r[IDX_W-1:0]), .rdata(na_dout)
  );

  slpa_ram #(.WIDTH(64), .DEPTH(MAX_VERTICES)) u_verts_b (
    .clk(clk), .we(we_b), .waddr(in_index), .wdata({in_px, in_py}),
    .re(re_b), .raddr(k_r[IDX_W-1:0]), .rdata(vb_dout)
  );

  assign dot_state = (state_r != S_IDLE) && (state_r != S_AFETCH) &&
                     (state_r != S_BFETCH);
  assign sel = ph_r[0];

  // supporting-point offset for the face distance
  assign dx_c = 64'(bx_r) - 64'(v2x_r);
  assign dy_c = 64'(by_r) - 64'(v2y_r);

  // operand select for the shared multiplier; phase 1 takes the second pair
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state_r)
      S_N1X: begin
        op_a = sel ? AW'(rot_a_r[1]) : AW'(rot_a_r[0]);
        op_b = sel ? BW'($signed(na_dout[17:0])) : BW'($signed(na_dout[35:18]));
      end
      S_N1Y: begin
        op_a = sel ? AW'(rot_a_r[3]) : AW'(rot_a_r[2]);
        op_b = sel ? BW'($signed(na_dout[17:0])) : BW'($signed(na_dout[35:18]));
      end
      S_N2X: begin
        op_a = sel ? AW'(rot_b_r[2]) : AW'(rot_b_r[0]);
        op_b = sel ? BW'(n1y_r) : BW'(n1x_r);
      end
      S_N2Y: begin
        op_a = sel ? AW'(rot_b_r[3]) : AW'(rot_b_r[1]);
        op_b = sel ? BW'(n1y_r) : BW'(n1x_r);
      end
      S_V1X: begin
        op_a = sel ? AW'(rot_a_r[1]) : AW'(rot_a_r[0]);
        op_b = sel ? BW'($signed(va_dout[31:0])) : BW'($signed(va_dout[63:32]));
      end
      S_V1Y: begin
        op_a = sel ? AW'(rot_a_r[3]) : AW'(rot_a_r[2]);
        op_b = sel ? BW'($signed(va_dout[31:0])) : BW'($signed(va_dout[63:32]));
      end
      S_V2X: begin
        op_a = sel ? AW'(rot_b_r[2]) : AW'(rot_b_r[0]);
        op_b = sel ? BW'(wy_r) : BW'(wx_r);
      end
      S_V2Y: begin
        op_a = sel ? AW'(rot_b_r[3]) : AW'(rot_b_r[1]);
        op_b = sel ? BW'(wy_r) : BW'(wx_r);
      end
      S_SUP: begin
        op_a = sel ? AW'(n2y_r) : AW'(n2x_r);
        op_b = sel ? BW'($signed(vb_dout[31:0])) : BW'($signed(vb_dout[63:32]));
      end
      S_DIST: begin
        op_a = sel ? AW'(n2y_r) : AW'(n2x_r);
        op_b = sel ? BW'(dy_c) : BW'(dx_c);
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign mul_c = op_a * op_b;
  assign sum_c = acc_r + prod_r;
  assign sh_c  = sum_c >>> FRAC_BITS;
  // projection on the negated normal, same wrap as negating the normal first
  assign p_c   = 64'sd0 - sum_c;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && (in_cmd == slpa_pkg::CMD_QUERY) &&
            (cnt_a_r != '0) && (cnt_b_r != '0)) begin
          state_nxt = S_AFETCH;
        end
      end
      S_AFETCH: state_nxt = S_N1X;
      S_BFETCH: state_nxt = S_SUP;
      default: begin
        if (ph_r == PH_LAST) begin
          case (state_r)
            S_N1X: state_nxt = S_N1Y;
            S_N1Y: state_nxt = S_N2X;
            S_N2X: state_nxt = S_N2Y;
            S_N2Y: state_nxt = S_V1X;
            S_V1X: state_nxt = S_V1Y;
            S_V1Y: state_nxt = S_V2X;
            S_V2X: state_nxt = S_V2Y;
            S_V2Y: state_nxt = S_BFETCH;
            S_SUP: begin
              state_nxt = (CNT_W'(k_r + 1'b1) == cnt_b_r) ? S_DIST : S_BFETCH;
            end
            S_DIST: begin
              state_nxt = (CNT_W'(face_r + 1'b1) == cnt_a_r) ? S_IDLE : S_AFETCH;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ph_r        <= '0;
      cnt_a_r     <= '0;
      cnt_b_r     <= '0;
      pos_ax_r    <= '0;
      pos_ay_r    <= '0;
      pos_bx_r    <= '0;
      pos_by_r    <= '0;
      rot_a_r[0]  <= ROT_W'(1 << FRAC_BITS);
      rot_a_r[1]  <= '0;
      rot_a_r[2]  <= '0;
      rot_a_r[3]  <= ROT_W'(1 << FRAC_BITS);
      rot_b_r[0]  <= ROT_W'(1 << FRAC_BITS);
      rot_b_r[1]  <= '0;
      rot_b_r[2]  <= '0;
      rot_b_r[3]  <= ROT_W'(1 << FRAC_BITS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      // empty answer right after the query, full answer after the last face
      out_valid_r <= (accept && (in_cmd == slpa_pkg::CMD_QUERY) &&
                      ((cnt_a_r == '0) || (cnt_b_r == '0))) ||
                     ((state_r == S_DIST) && (ph_r == PH_LAST) &&
                      (CNT_W'(face_r + 1'b1) == cnt_a_r));
      if (dot_state) begin
        ph_r <= (ph_r == PH_LAST) ? 2'd0 : ph_r + 2'd1;
      end
      if (we_a && in_last_vertex) begin
        cnt_a_r <= CNT_W'(in_index) + CNT_W'(1);
      end
      if (we_b && in_last_vertex) begin
        cnt_b_r <= CNT_W'(in_index) + CNT_W'(1);
      end
      if (accept && (in_cmd == slpa_pkg::CMD_POSE_A)) begin
        pos_ax_r   <= in_px;
        pos_ay_r   <= in_py;
        rot_a_r[0] <= ROT_W'(in_m00);
        rot_a_r[1] <= ROT_W'(in_m01);
        rot_a_r[2] <= ROT_W'(in_m10);
        rot_a_r[3] <= ROT_W'(in_m11);
      end
      if (accept && (in_cmd == slpa_pkg::CMD_POSE_B)) begin
        pos_bx_r   <= in_px;
        pos_by_r   <= in_py;
        rot_b_r[0] <= ROT_W'(in_m00);
        rot_b_r[1] <= ROT_W'(in_m01);
        rot_b_r[2] <= ROT_W'(in_m10);
        rot_b_r[3] <= ROT_W'(in_m11);
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= 64'(mul_c);
    if (ph_r == 2'd1) begin
      acc_r <= prod_r;
    end
    if (accept && (in_cmd == slpa_pkg::CMD_QUERY)) begin
      face_r           <= '0;
      out_distance_r   <= '0;
      out_face_index_r <= '0;
      out_status_r     <= slpa_pkg::STATUS_EMPTY;
    end
    if (state_r == S_V2Y) begin
      k_r <= '0;
    end
    if (ph_r == PH_LAST) begin
      case (state_r)
        S_N1X: n1x_r <= N1_W'(sh_c);
        S_N1Y: n1y_r <= N1_W'(sh_c);
        S_N2X: n2x_r <= N2_W'(sh_c);
        S_N2Y: n2y_r <= N2_W'(sh_c);
        S_V1X: wx_r  <= V1P_W'(sh_c + 64'(pos_ax_r) - 64'(pos_bx_r));
        S_V1Y: wy_r  <= V1P_W'(sh_c + 64'(pos_ay_r) - 64'(pos_by_r));
        S_V2X: v2x_r <= V2_W'(sh_c);
        S_V2Y: v2y_r <= V2_W'(sh_c);
        S_SUP: begin
          // first strict maximum keeps the support vertex
          if ((k_r == '0) || (p_c > bestp_r)) begin
            bestp_r <= p_c;
            bx_r    <= $signed(vb_dout[63:32]);
            by_r    <= $signed(vb_dout[31:0]);
          end
          k_r <= CNT_W'(k_r + 1'b1);
        end
        S_DIST: begin
          if ((face_r == '0) || (sh_c > bestd_r)) begin
            bestd_r <= sh_c;
            besti_r <= face_r[IDX_W-1:0];
          end
          face_r <= CNT_W'(face_r + 1'b1);
          if (CNT_W'(face_r + 1'b1) == cnt_a_r) begin
            out_status_r <= slpa_pkg::STATUS_OK;
            if ((face_r == '0) || (sh_c > bestd_r)) begin
              out_face_index_r <= face_r[IDX_W-1:0];
              if (sh_c > 64'sd2147483647) begin
                out_distance_r <= 32'sh7fffffff;
              end else if (sh_c < -64'sd2147483648) begin
                out_distance_r <= 32'sh80000000;
              end else begin
                out_distance_r <= 32'(sh_c);
              end
            end else begin
              out_face_index_r <= besti_r;
              if (bestd_r > 64'sd2147483647) begin
                out_distance_r <= 32'sh7fffffff;
              end else if (bestd_r < -64'sd2147483648) begin
                out_distance_r <= 32'sh80000000;
              end else begin
                out_distance_r <= 32'(bestd_r);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_distance   = out_distance_r;
  assign out_face_index = out_face_index_r;
  assign out_status     = out_status_r;

endmodule

>>> hw/rtl/slpa_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module slpa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/slpa_checker.sv
// port-level checks for the least penetration axis block, bound to the top level
// depends on slpa_pkg
`timescale 1ns / 1ps
module slpa_checker #(
  parameter int MAX_VERTICES = slpa_pkg::MAX_VERTICES_DEF
) (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [slpa_pkg::CMD_W-1:0]      in_cmd,
  input logic                            out_valid,
  input logic signed [31:0]              out_distance,
  input logic [$clog2(MAX_VERTICES)-1:0] out_face_index,
  input logic                            out_status
);

  // an empty polygon answers with zero distance and face
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == slpa_pkg::STATUS_EMPTY)) |->
      ((out_distance == '0) && (out_face_index == '0)))
    else $error("empty result carries nonzero payload");

  // a result transfer only happens once the sequencer is back to idle
  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  // the sequencer only finishes by delivering a result
  a_fall_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("query ended without a result");

  // an accepted query either starts working or answers at once
  a_query_reacts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == slpa_pkg::CMD_QUERY)) |=> (busy || out_valid))
    else $error("query accepted but nothing happened");

  // a full result follows a busy stretch
  a_valid_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == slpa_pkg::STATUS_OK)) |-> $past(busy))
    else $error("valid result without preceding work");

endmodule

bind sat_least_penetration_axis slpa_checker #(.MAX_VERTICES(MAX_VERTICES)) u_slpa_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_cmd(in_cmd),
  .out_valid(out_valid), .out_distance(out_distance),
  .out_face_index(out_face_index), .out_status(out_status)
);

>>> test/slpa_checker.sv
// checker for the least penetration axis block: watches the command and result
// transfers, predicts each query answer and compares field by field. uses slpa_pkg
`timescale 1ns / 1ps
module slpa_scoreboard (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  logic [2:0]         in_cmd,
  input  logic [2:0]         in_index,
  input  logic               in_last_vertex,
  input  logic signed [31:0] in_px,
  input  logic signed [31:0] in_py,
  input  logic signed [17:0] in_nx,
  input  logic signed [17:0] in_ny,
  input  logic signed [17:0] in_m00,
  input  logic signed [17:0] in_m01,
  input  logic signed [17:0] in_m10,
  input  logic signed [17:0] in_m11,
  input  logic               out_valid,
  input  logic signed [31:0] out_distance,
  input  logic [2:0]         out_face_index,
  input  logic               out_status,
  output int                 fail_count,
  output int                 answers_owed
);
  import slpa_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;
  localparam int FB = FRAC_BITS_DEF;

  typedef logic [63:0] word_t;
  typedef struct packed {
    logic signed [31:0] distance;
    logic [2:0]         face;
    logic               status;
  } answer_t;

  word_t ax[NV], ay[NV], anx[NV], any_[NV], bx[NV], by[NV];
  word_t pax, pay, pbx, pby;
  word_t ra[4], rb[4];
  int unsigned cnt_a, cnt_b;
  answer_t answers[$];

  function automatic word_t floor_shift(word_t u);
    return word_t'($signed(u) >>> FB);
  endfunction

  function automatic word_t sx32(logic signed [31:0] v);
    return word_t'(64'(v));
  endfunction

  function automatic word_t sx18(logic signed [17:0] v);
    return word_t'(64'(v));
  endfunction

  // distance of face i of A against B, computed in B's frame
  function automatic logic signed [63:0] face_depth(int i);
    word_t n0, n1, nx, ny, v0, v1, vx, vy, sbx, sby;
    logic signed [63:0] proj, bestp;
    n0 = floor_shift(ra[0] * anx[i] + ra[1] * any_[i]);
    n1 = floor_shift(ra[2] * anx[i] + ra[3] * any_[i]);
    nx = floor_shift(rb[0] * n0 + rb[2] * n1);
    ny = floor_shift(rb[1] * n0 + rb[3] * n1);
    v0 = floor_shift(ra[0] * ax[i] + ra[1] * ay[i]) + pax - pbx;
    v1 = floor_shift(ra[2] * ax[i] + ra[3] * ay[i]) + pay - pby;
    vx = floor_shift(rb[0] * v0 + rb[2] * v1);
    vy = floor_shift(rb[1] * v0 + rb[3] * v1);
    sbx = bx[0];
    sby = by[0];
    bestp = 0;
    for (int k = 0; k < cnt_b; k++) begin
      proj = $signed((64'd0 - nx) * bx[k] + (64'd0 - ny) * by[k]);
      if (k == 0 || proj > bestp) begin
        bestp = proj;
        sbx = bx[k];
        sby = by[k];
      end
    end
    return $signed(floor_shift(nx * (sbx - vx) + ny * (sby - vy)));
  endfunction

  function automatic answer_t query_answer();
    answer_t r;
    logic signed [63:0] d, bestd;
    r.face = 0;
    if (cnt_a == 0 || cnt_b == 0) begin
      r.distance = 0;
      r.status = STATUS_EMPTY;
      return r;
    end
    bestd = 0;
    for (int i = 0; i < cnt_a; i++) begin
      d = face_depth(i);
      if (i == 0 || d > bestd) begin
        bestd = d;
        r.face = 3'(i);
      end
    end
    if (bestd > 64'sd2147483647) bestd = 64'sd2147483647;
    if (bestd < -64'sd2147483648) bestd = -64'sd2147483648;
    r.distance = bestd[31:0];
    r.status = STATUS_OK;
    return r;
  endfunction

  assign answers_owed = answers.size();

  always @(posedge clk) begin
    answer_t e;
    int errs;
    errs = 0;
    if (!rst_n) begin
      cnt_a <= 0;
      cnt_b <= 0;
      pax = 0; pay = 0; pbx = 0; pby = 0;
      ra[0] = 64'd1 << FB; ra[1] = 0; ra[2] = 0; ra[3] = 64'd1 << FB;
      rb = ra;
      answers.delete();
      fail_count <= 0;
    end else begin
      if (out_valid) begin
        if (answers.size() == 0) begin
          $error("result transfer with no query outstanding");
          errs++;
        end else begin
          e = answers.pop_front();
          if (out_distance !== e.distance) begin
            $error("distance: expected %0d, got %0d", e.distance, out_distance);
            errs++;
          end
          if (out_face_index !== e.face) begin
            $error("face_index: expected %0d, got %0d", e.face, out_face_index);
            errs++;
          end
          if (out_status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, out_status);
            errs++;
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (start && !busy) begin
        case (in_cmd)
          CMD_LOAD_A: begin
            ax[in_index] = sx32(in_px);
            ay[in_index] = sx32(in_py);
            anx[in_index] = sx18(in_nx);
            any_[in_index] = sx18(in_ny);
            if (in_last_vertex) cnt_a <= in_index + 1;
          end
          CMD_LOAD_B: begin
            bx[in_index] = sx32(in_px);
            by[in_index] = sx32(in_py);
            if (in_last_vertex) cnt_b <= in_index + 1;
          end
          CMD_POSE_A, CMD_POSE_B: begin
            if (in_cmd == CMD_POSE_A) begin
              pax = sx32(in_px); pay = sx32(in_py);
              ra[0] = sx18(in_m00); ra[1] = sx18(in_m01);
              ra[2] = sx18(in_m10); ra[3] = sx18(in_m11);
            end else begin
              pbx = sx32(in_px); pby = sx32(in_py);
              rb[0] = sx18(in_m00); rb[1] = sx18(in_m01);
              rb[2] = sx18(in_m10); rb[3] = sx18(in_m11);
            end
          end
          CMD_QUERY: answers.push_back(query_answer());
          default: ;
        endcase
      end
    end
  end
endmodule

>>> test/tb_top.sv
// top of the least penetration axis testbench: clock, reset, command stimulus
// and the verdict. depends on slpa_pkg, sat_least_penetration_axis, slpa_scoreboard
`timescale 1ns / 1ps
module tb_top;
  import slpa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;

  logic clk, rst_n, start, busy;
  logic [2:0] in_cmd, in_index;
  logic in_last_vertex;
  logic signed [31:0] in_px, in_py;
  logic signed [17:0] in_nx, in_ny, in_m00, in_m01, in_m10, in_m11;
  logic out_valid, out_status;
  logic signed [31:0] out_distance;
  logic [2:0] out_face_index;
  int fail_count, answers_owed;
  int items_sent, idle_cycles;
  logic [7:0] written_a, written_b;

  sat_least_penetration_axis dut (.*);

  slpa_scoreboard chk (.*);

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // watchdog: any cycle without a transfer counts toward the limit
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic signed [31:0] rnd_coord();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return int'($urandom_range(0, 2097152)) - 1048576;
      default: return int'($urandom_range(0, 1 << 25)) - (1 << 24);
    endcase
  endfunction

  function automatic logic signed [17:0] rnd_unit();
    case ($urandom_range(0, 7))
      0: return 18'sd65536;
      1: return -18'sd65536;
      default: return 18'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  // one command transfer; the gap afterward is random, mostly short
  task automatic send(input logic [2:0] cmd, input logic [2:0] idx, input logic lst,
                      input logic signed [31:0] x, input logic signed [31:0] y,
                      input logic signed [17:0] nx, input logic signed [17:0] ny,
                      input logic signed [17:0] a, input logic signed [17:0] b,
                      input logic signed [17:0] c, input logic signed [17:0] d);
    int gap;
    start <= 1'b1;
    in_cmd <= cmd; in_index <= idx; in_last_vertex <= lst;
    in_px <= x; in_py <= y; in_nx <= nx; in_ny <= ny;
    in_m00 <= a; in_m01 <= b; in_m10 <= c; in_m11 <= d;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
    if (cmd == CMD_LOAD_A) written_a[idx] = 1'b1;
    if (cmd == CMD_LOAD_B) written_b[idx] = 1'b1;
    items_sent++;
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3: gap = $urandom_range(10, 60);
      default: gap = 0;
    endcase
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_poly(input logic is_a, input int n);
    for (int i = 0; i < n; i++)
      send(is_a ? CMD_LOAD_A : CMD_LOAD_B, 3'(i), i == n - 1, rnd_coord(), rnd_coord(),
           rnd_unit(), rnd_unit(), 0, 0, 0, 0);
  endtask

  task automatic pose(input logic is_a);
    send(is_a ? CMD_POSE_A : CMD_POSE_B, 3'($urandom), 1'($urandom),
         rnd_coord(), rnd_coord(), 18'($urandom), 18'($urandom),
         rnd_unit(), rnd_unit(), rnd_unit(), rnd_unit());
  endtask

  task automatic query();
    send(CMD_QUERY, 3'($urandom), 1'($urandom), 32'($urandom), 32'($urandom),
         18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
         18'($urandom), 18'($urandom));
  endtask

  function automatic int rnd_size();
    return ($urandom_range(0, 9) == 0) ? 8 : $urandom_range(1, 4);
  endfunction

  initial begin
    int n;
    logic [2:0] idx;
    logic lst;
    start <= 0; rst_n <= 0; in_cmd <= 0; in_index <= 0; in_last_vertex <= 0;
    in_px <= 0; in_py <= 0; in_nx <= 0; in_ny <= 0;
    in_m00 <= 0; in_m01 <= 0; in_m10 <= 0; in_m11 <= 0;
    idle_cycles <= 0;
    items_sent = 0;
    written_a = 0;
    written_b = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // both polygons empty, then only B empty
    query();
    send(CMD_LOAD_A, 0, 1, 32'sd65536, -32'sd65536, 18'sd65536, 0, 0, 0, 0, 0);
    query();
    // unit square against itself at identity: every face ties
    send(CMD_LOAD_A, 0, 0, -32'sd65536, -32'sd65536, 0, -18'sd65536, 0, 0, 0, 0);
    send(CMD_LOAD_A, 1, 0, 32'sd65536, -32'sd65536, 18'sd65536, 0, 0, 0, 0, 0);
    send(CMD_LOAD_A, 2, 0, 32'sd65536, 32'sd65536, 0, 18'sd65536, 0, 0, 0, 0);
    send(CMD_LOAD_A, 3, 1, -32'sd65536, 32'sd65536, -18'sd65536, 0, 0, 0, 0, 0);
    send(CMD_LOAD_B, 0, 0, -32'sd65536, -32'sd65536, 0, 0, 0, 0, 0, 0);
    send(CMD_LOAD_B, 1, 0, 32'sd65536, -32'sd65536, 0, 0, 0, 0, 0, 0);
    send(CMD_LOAD_B, 2, 0, 32'sd65536, 32'sd65536, 0, 0, 0, 0, 0, 0);
    send(CMD_LOAD_B, 3, 1, -32'sd65536, 32'sd65536, 0, 0, 0, 0, 0, 0);
    query();
    // far apart bodies with extreme rotations push the distance into saturation
    send(CMD_POSE_A, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0,
         -18'sd65536, 18'sd65536, 18'sd65536, -18'sd65536);
    send(CMD_POSE_B, 0, 0, 32'h80000000, 32'h80000000, 0, 0,
         18'sd65536, -18'sd65536, -18'sd65536, 18'sd65536);
    query();
    send(CMD_POSE_A, 0, 0, 32'h80000000, 32'h7fffffff, 0, 0,
         18'sd65536, 0, 0, 18'sd65536);
    query();
    // unknown commands do nothing
    send(3'd5, 7, 1, 32'hffffffff, 0, 0, 0, 0, 0, 0, 0);
    send(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send(3'd7, 7, 1, 0, 32'hffffffff, 0, 0, 0, 0, 0, 0);
    // eight-vertex polygons at the slot limit
    load_poly(1, 8);
    load_poly(0, 8);
    query();

    while (items_sent < 1100) begin
      case ($urandom_range(0, 11))
        0, 1: load_poly(1, rnd_size());
        2, 3: load_poly(0, rnd_size());
        4, 5: pose($urandom_range(0, 1));
        6, 7, 8: query();
        9: send(3'($urandom_range(5, 7)), 3'($urandom), 1'($urandom),
                32'($urandom), 32'($urandom), 18'($urandom), 18'($urandom),
                18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom));
        10: begin
          // stray load; a count mark only when every slot up to its own is already loaded
          idx = 3'($urandom);
          n = $urandom_range(0, 1);
          lst = (n == 1) ? ((written_a | ~(8'hff >> (7 - idx))) == 8'hff) : 1'b0;
          lst = lst & ($urandom_range(0, 1) == 1);
          send(CMD_LOAD_A, idx, lst, rnd_coord(), rnd_coord(), rnd_unit(), rnd_unit(),
               0, 0, 0, 0);
          idx = 3'($urandom);
          lst = (written_b >> idx) == (written_b >> idx) &&
                (written_b | ~(8'hff >> (7 - idx))) == 8'hff && $urandom_range(0, 1);
          send(CMD_LOAD_B, idx, lst, rnd_coord(), rnd_coord(),
               18'($urandom), 18'($urandom), 18'($urandom), 18'($urandom),
               18'($urandom), 18'($urandom));
        end
        default: begin
          // hold off until every outstanding answer is back
          start <= 1'b0;
          @(posedge clk);
          while (answers_owed != 0) @(posedge clk);
        end
      endcase
    end

    start <= 1'b0;
    @(posedge clk);
    while (answers_owed != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end
endmodule
